// File: rtl/xdr_pkg.sv
// ----------------------------------------------------------------------------
// xdr_pkg
// Shared types, codes and keyword tables for the XML declaration recognizer.
// ----------------------------------------------------------------------------
package xdr_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    typedef enum logic [6:0] {
        S_IDLE, S_MARKUP, S_PI1, S_PI2, S_PI3, S_PI4,
        S_V1, S_V2, S_V3, S_V4, S_V5, S_V6, S_V7,
        S_VV1, S_VV2, S_VV3, S_VV4, S_VQ, S_VA, S_ENC_WS,
        S_EN1, S_EN2, S_EN3, S_EN4, S_EN5, S_EN6, S_EN7, S_EN8,
        S_EV1, S_EV2, S_UTF1, S_UTF2, S_UTF3, S_UTF4, S_UTF8, S_U16A, S_U16B,
        S_BE1, S_BE2, S_LE1, S_LE2, S_ISO1, S_ISO2, S_ISO3, S_ISO4,
        S_UCS1, S_UCS2, S_UCS3, S_UCS4, S_UCS5, S_UCS6, S_UCS7, S_UCS8, S_UCS9,
        S_UCS10, S_UCSQ, S_LAT1, S_LAT2, S_LAT3, S_LAT4, S_LAT5, S_LAT6,
        S_EQ, S_EA, S_SA_WS, S_SA1, S_SA2, S_SA3, S_SA4, S_SA5, S_SA6, S_SA7,
        S_SA8, S_SA9, S_SA10, S_SV1, S_SV2, S_YES1, S_YES2, S_NO, S_SQ, S_SAP,
        S_QUEST, S_SEENQ, S_WS, S_EQUALS
    } state_t;

    localparam logic [3:0] TK_NONE       = 4'd0;
    localparam logic [3:0] TK_PI_NAME    = 4'd1;
    localparam logic [3:0] TK_VERSION    = 4'd2;
    localparam logic [3:0] TK_ENC_OTHER  = 4'd3;
    localparam logic [3:0] TK_UTF8       = 4'd4;
    localparam logic [3:0] TK_UTF16      = 4'd5;
    localparam logic [3:0] TK_UTF16BE    = 4'd6;
    localparam logic [3:0] TK_UTF16LE    = 4'd7;
    localparam logic [3:0] TK_UCS4       = 4'd8;
    localparam logic [3:0] TK_LATIN1     = 4'd9;
    localparam logic [3:0] TK_STANDALONE = 4'd10;

    localparam logic [1:0] ER_NONE     = 2'd0;
    localparam logic [1:0] ER_BAD_CHAR = 2'd1;
    localparam logic [1:0] ER_VERSION  = 2'd2;
    localparam logic [1:0] ER_ENCODING = 2'd3;

    localparam logic [3:0] HO_STAY     = 4'd0;
    localparam logic [3:0] HO_ELEMENT  = 4'd1;
    localparam logic [3:0] HO_COMMENT  = 4'd2;
    localparam logic [3:0] HO_PI_START = 4'd3;
    localparam logic [3:0] HO_PI_WS    = 4'd4;
    localparam logic [3:0] HO_PI_QUEST = 4'd5;
    localparam logic [3:0] HO_PI_X     = 4'd6;
    localparam logic [3:0] HO_PI_XM    = 4'd7;
    localparam logic [3:0] HO_PI_NAME  = 4'd8;
    localparam logic [3:0] HO_DONE     = 4'd9;

    typedef enum logic [1:0] {
        LM_NONE, LM_KEYWORD, LM_LETTER
    } lit_mode_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        state_t     nxt;
        state_t     store;
        logic [1:0] err;
        lit_mode_t  mode;
    } lit_entry_t;

    typedef struct packed {
        state_t     ns;
        state_t     nr;
        logic       cons;
        logic [1:0] err;
        logic [3:0] kind;
        logic [3:0] hand;
        logic       mark_ld;
        logic       v11_set;
    } eval_out_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic        version_eleven;
        logic        consumed;
        logic [3:0]  handoff;
        logic [1:0]  error_code;
        logic [15:0] token_finish;
        logic [15:0] token_begin;
        logic [3:0]  token_kind;
    } result_t;

    function automatic lit_entry_t kw(logic [7:0] ch, state_t nx, state_t st, logic [1:0] er);
        lit_entry_t e;
        e = '{a: ch, b: ch, nxt: nx, store: st, err: er, mode: LM_KEYWORD};
        return e;
    endfunction

    function automatic lit_entry_t lt(logic [7:0] x, logic [7:0] y, state_t nx);
        lit_entry_t e;
        e = '{a: x, b: y, nxt: nx, store: S_IDLE, err: ER_NONE, mode: LM_LETTER};
        return e;
    endfunction

    function automatic lit_entry_t lit_lookup(state_t st);
        lit_entry_t e;
        e = '{a: 8'd0, b: 8'd0, nxt: S_IDLE, store: S_IDLE, err: ER_NONE, mode: LM_NONE};
        case (st)
            S_V1:    e = kw("v", S_V2, S_IDLE, ER_BAD_CHAR);
            S_V2:    e = kw("e", S_V3, S_IDLE, ER_BAD_CHAR);
            S_V3:    e = kw("r", S_V4, S_IDLE, ER_BAD_CHAR);
            S_V4:    e = kw("s", S_V5, S_IDLE, ER_BAD_CHAR);
            S_V5:    e = kw("i", S_V6, S_IDLE, ER_BAD_CHAR);
            S_V6:    e = kw("o", S_V7, S_IDLE, ER_BAD_CHAR);
            S_V7:    e = kw("n", S_EQUALS, S_VV1, ER_BAD_CHAR);
            S_VV2:   e = kw("1", S_VV3, S_IDLE, ER_VERSION);
            S_VV3:   e = kw(".", S_VV4, S_IDLE, ER_VERSION);
            S_EN2:   e = kw("n", S_EN3, S_IDLE, ER_BAD_CHAR);
            S_EN3:   e = kw("c", S_EN4, S_IDLE, ER_BAD_CHAR);
            S_EN4:   e = kw("o", S_EN5, S_IDLE, ER_BAD_CHAR);
            S_EN5:   e = kw("d", S_EN6, S_IDLE, ER_BAD_CHAR);
            S_EN6:   e = kw("i", S_EN7, S_IDLE, ER_BAD_CHAR);
            S_EN7:   e = kw("n", S_EN8, S_IDLE, ER_BAD_CHAR);
            S_EN8:   e = kw("g", S_EQUALS, S_EV1, ER_BAD_CHAR);
            S_SA2:   e = kw("t", S_SA3, S_IDLE, ER_BAD_CHAR);
            S_SA3:   e = kw("a", S_SA4, S_IDLE, ER_BAD_CHAR);
            S_SA4:   e = kw("n", S_SA5, S_IDLE, ER_BAD_CHAR);
            S_SA5:   e = kw("d", S_SA6, S_IDLE, ER_BAD_CHAR);
            S_SA6:   e = kw("a", S_SA7, S_IDLE, ER_BAD_CHAR);
            S_SA7:   e = kw("l", S_SA8, S_IDLE, ER_BAD_CHAR);
            S_SA8:   e = kw("o", S_SA9, S_IDLE, ER_BAD_CHAR);
            S_SA9:   e = kw("n", S_SA10, S_IDLE, ER_BAD_CHAR);
            S_SA10:  e = kw("e", S_EQUALS, S_SV1, ER_BAD_CHAR);
            S_YES1:  e = kw("e", S_YES2, S_IDLE, ER_BAD_CHAR);
            S_UTF1:  e = lt("T", "t", S_UTF2);
            S_UTF2:  e = lt("F", "f", S_UTF3);
            S_UTF3:  e = lt("-", "-", S_UTF4);
            S_U16A:  e = lt("6", "6", S_U16B);
            S_BE1:   e = lt("E", "e", S_BE2);
            S_LE1:   e = lt("E", "e", S_LE2);
            S_ISO1:  e = lt("S", "s", S_ISO2);
            S_ISO2:  e = lt("O", "o", S_ISO3);
            S_ISO3:  e = lt("-", "-", S_ISO4);
            S_UCS1:  e = lt("0", "0", S_UCS2);
            S_UCS2:  e = lt("6", "6", S_UCS3);
            S_UCS3:  e = lt("4", "4", S_UCS4);
            S_UCS4:  e = lt("6", "6", S_UCS5);
            S_UCS5:  e = lt("-", "-", S_UCS6);
            S_UCS6:  e = lt("U", "u", S_UCS7);
            S_UCS7:  e = lt("C", "c", S_UCS8);
            S_UCS8:  e = lt("S", "s", S_UCS9);
            S_UCS9:  e = lt("-", "-", S_UCS10);
            S_UCS10: e = lt("4", "4", S_UCSQ);
            S_LAT1:  e = lt("8", "8", S_LAT2);
            S_LAT2:  e = lt("5", "5", S_LAT3);
            S_LAT3:  e = lt("9", "9", S_LAT4);
            S_LAT4:  e = lt("-", "-", S_LAT5);
            S_LAT5:  e = lt("1", "1", S_LAT6);
            default: e.mode = LM_NONE;
        endcase
        return e;
    endfunction

endpackage

// File: rtl/xdr_eval.sv
// ----------------------------------------------------------------------------
// xdr_eval
// One evaluation of the declaration state machine for a single character.
// ----------------------------------------------------------------------------
module xdr_eval (
    input  xdr_pkg::state_t    state_i,
    input  xdr_pkg::state_t    ret_i,
    input  logic [7:0]         char_i,
    output xdr_pkg::eval_out_t out_o
);
    import xdr_pkg::*;

    logic       ws;
    logic       alpha;
    logic       quote;
    logic       name_ch;
    logic       close_ok;
    lit_entry_t lit;

    assign ws      = (char_i == 8'h20) || (char_i == 8'h09) || (char_i == 8'h0A)
                  || (char_i == 8'h0D);
    assign alpha   = ((char_i >= "A") && (char_i <= "Z")) || ((char_i >= "a") && (char_i <= "z"));
    assign quote   = (char_i == "\"") || (char_i == "'");
    assign name_ch = alpha || ((char_i >= "0") && (char_i <= "9")) || (char_i == ".")
                  || (char_i == "_") || (char_i == "-");
    assign close_ok = ((char_i == "\"") && (ret_i == S_EQ)) || ((char_i == "'") && (ret_i == S_EA));
    assign lit     = lit_lookup(state_i);

    always_comb begin
        out_o         = '0;
        out_o.ns      = state_i;
        out_o.nr      = ret_i;
        out_o.cons    = 1'b1;
        out_o.err     = ER_NONE;
        out_o.kind    = TK_NONE;
        out_o.hand    = HO_STAY;
        case (state_i)
            S_MARKUP: begin
                if (char_i == "?") begin
                    out_o.ns      = S_PI1;
                    out_o.mark_ld = 1'b1;
                end else begin
                    out_o.hand = (char_i == "!") ? HO_COMMENT : HO_ELEMENT;
                    out_o.ns   = S_IDLE;
                end
            end
            S_PI1: begin
                if (char_i == "x") begin
                    out_o.ns = S_PI2;
                end else begin
                    out_o.hand = HO_PI_START;
                    out_o.ns   = S_IDLE;
                    out_o.cons = 1'b0;
                end
            end
            S_PI2, S_PI3: begin
                if (char_i == ((state_i == S_PI2) ? "m" : "l")) begin
                    out_o.ns = (state_i == S_PI2) ? S_PI3 : S_PI4;
                end else if (ws || (char_i == "?")) begin
                    out_o.kind = TK_PI_NAME;
                    out_o.hand = ws ? HO_PI_WS : HO_PI_QUEST;
                    out_o.ns   = S_IDLE;
                end else begin
                    out_o.hand = (state_i == S_PI2) ? HO_PI_X : HO_PI_XM;
                    out_o.ns   = S_IDLE;
                    out_o.cons = 1'b0;
                end
            end
            S_PI4: begin
                if (ws) begin
                    out_o.nr = S_V1;
                    out_o.ns = S_WS;
                end else if (char_i == "?") begin
                    out_o.ns  = S_SEENQ;
                    out_o.err = ER_BAD_CHAR;
                end else begin
                    out_o.hand = HO_PI_NAME;
                    out_o.ns   = S_IDLE;
                end
            end
            S_VV1, S_EV1, S_SV1: begin
                if (quote) begin
                    out_o.mark_ld = 1'b1;
                    unique case (state_i)
                        S_VV1: begin
                            out_o.nr = (char_i == "\"") ? S_VQ : S_VA;
                            out_o.ns = S_VV2;
                        end
                        S_EV1: begin
                            out_o.nr = (char_i == "\"") ? S_EQ : S_EA;
                            out_o.ns = S_EV2;
                        end
                        default: begin
                            out_o.nr = (char_i == "\"") ? S_SQ : S_SAP;
                            out_o.ns = S_SV2;
                        end
                    endcase
                end else begin
                    out_o.err = ER_BAD_CHAR;
                end
            end
            S_VV4: begin
                out_o.ns = ret_i;
                if (char_i == "1") begin
                    out_o.v11_set = 1'b1;
                end else if (char_i != "0") begin
                    out_o.err = ER_VERSION;
                end
            end
            S_VQ, S_VA, S_SQ, S_SAP: begin
                if (char_i != (((state_i == S_VQ) || (state_i == S_SQ)) ? "\"" : "'")) begin
                    out_o.err = ((state_i == S_VQ) || (state_i == S_VA)) ? ER_VERSION : ER_BAD_CHAR;
                end else if ((state_i == S_VQ) || (state_i == S_VA)) begin
                    out_o.kind = TK_VERSION;
                    out_o.ns   = S_ENC_WS;
                end else begin
                    out_o.kind = TK_STANDALONE;
                    out_o.nr   = S_QUEST;
                    out_o.ns   = S_WS;
                end
            end
            S_ENC_WS, S_SA_WS: begin
                if (ws) begin
                    if (state_i == S_ENC_WS) begin
                        out_o.nr = S_EN1;
                        out_o.ns = S_WS;
                    end else begin
                        out_o.ns = S_SA1;
                    end
                end else if (char_i == "?") begin
                    out_o.ns = S_SEENQ;
                end else begin
                    out_o.err = ER_BAD_CHAR;
                end
            end
            S_EN1, S_SA1, S_QUEST: begin
                if (ws) begin
                    out_o.ns = state_i;
                end else if (char_i == "?") begin
                    out_o.ns = S_SEENQ;
                end else if ((char_i == "s") && (state_i != S_QUEST)) begin
                    out_o.ns = S_SA2;
                end else if ((char_i == "e") && (state_i == S_EN1)) begin
                    out_o.ns = S_EN2;
                end else begin
                    out_o.err = ER_BAD_CHAR;
                end
            end
            S_EV2: begin
                if ((char_i == "U") || (char_i == "u")) begin
                    out_o.ns = S_UTF1;
                end else if ((char_i == "I") || (char_i == "i")) begin
                    out_o.ns = S_ISO1;
                end else begin
                    out_o.ns = ret_i;
                    if (!alpha) begin
                        out_o.err  = ER_ENCODING;
                        out_o.cons = !quote;
                    end
                end
            end
            S_UTF4, S_ISO4: begin
                if (char_i == "1") begin
                    out_o.ns = (state_i == S_UTF4) ? S_U16A : S_UCS1;
                end else if (char_i == "8") begin
                    out_o.ns = (state_i == S_UTF4) ? S_UTF8 : S_LAT1;
                end else begin
                    out_o.ns   = ret_i;
                    out_o.cons = 1'b0;
                end
            end
            S_UTF8, S_U16B, S_BE2, S_LE2, S_UCSQ, S_LAT6: begin
                if ((state_i == S_U16B) && ((char_i == "B") || (char_i == "b"))) begin
                    out_o.ns = S_BE1;
                end else if ((state_i == S_U16B) && ((char_i == "L") || (char_i == "l"))) begin
                    out_o.ns = S_LE1;
                end else if (close_ok) begin
                    out_o.ns = S_SA_WS;
                    unique case (state_i)
                        S_UTF8:  out_o.kind = TK_UTF8;
                        S_U16B:  out_o.kind = TK_UTF16;
                        S_BE2:   out_o.kind = TK_UTF16BE;
                        S_LE2:   out_o.kind = TK_UTF16LE;
                        S_UCSQ:  out_o.kind = TK_UCS4;
                        default: out_o.kind = TK_LATIN1;
                    endcase
                end else begin
                    out_o.ns   = ret_i;
                    out_o.cons = 1'b0;
                end
            end
            S_EQ, S_EA: begin
                if (char_i == ((state_i == S_EQ) ? "\"" : "'")) begin
                    out_o.kind = TK_ENC_OTHER;
                    out_o.ns   = S_SA_WS;
                end else if (!name_ch) begin
                    out_o.err = ER_ENCODING;
                end
            end
            S_SV2: begin
                if (char_i == "y") begin
                    out_o.ns = S_YES1;
                end else if (char_i == "n") begin
                    out_o.ns = S_NO;
                end else begin
                    out_o.ns  = ret_i;
                    out_o.err = ER_BAD_CHAR;
                end
            end
            S_YES2, S_NO: begin
                out_o.ns = ret_i;
                if (char_i != ((state_i == S_NO) ? "o" : "s")) begin
                    out_o.err = ER_BAD_CHAR;
                end
            end
            S_SEENQ: begin
                if (char_i == ">") begin
                    out_o.hand = HO_DONE;
                    out_o.ns   = S_IDLE;
                end else begin
                    out_o.err = ER_BAD_CHAR;
                end
            end
            S_WS: begin
                if (!ws) begin
                    out_o.ns   = ret_i;
                    out_o.cons = 1'b0;
                end
            end
            S_EQUALS: begin
                if (char_i == "=") begin
                    out_o.ns = S_WS;
                end else if (!ws) begin
                    out_o.err = ER_BAD_CHAR;
                end
            end
            default: begin
                if (lit.mode == LM_NONE) begin
                    out_o.ns   = S_IDLE;
                    out_o.cons = 1'b0;
                end else if ((char_i == lit.a) || (char_i == lit.b)) begin
                    if (lit.store != S_IDLE) begin
                        out_o.nr = lit.store;
                    end
                    out_o.ns = lit.nxt;
                end else if (lit.mode == LM_KEYWORD) begin
                    out_o.err = lit.err;
                end else begin
                    out_o.ns   = ret_i;
                    out_o.cons = 1'b0;
                end
            end
        endcase
    end

endmodule

// File: rtl/xml_declaration_recognizer.sv
// ----------------------------------------------------------------------------
// xml_declaration_recognizer
// Character-at-a-time recognizer for an XML declaration after '<'.
// ----------------------------------------------------------------------------
// One character request is taken per cycle and yields one result request. The
// state machine step (up to two chained evaluations when a character is handed
// back) sits between input handshake and result register, so results show in
// the next cycle; throughput is one character per cycle while m_tready holds.
// Assert s_tuser on the first character after '<' to restart recognition.
module xml_declaration_recognizer #(
    parameter int OFFSET_BITS = xdr_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] markup_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // kind, begin, finish, error, handoff,
                                   // consumed, version_eleven, zero pad
);
    import xdr_pkg::*;

    state_t                 state_reg, state_next;
    state_t                 ret_reg, ret_next;
    logic                   v11_reg, v11_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] mark_reg, mark_next;
    logic                   m_valid_reg;
    result_t                res_reg, res_next;

    state_t                 st0, rt0;
    logic [OFFSET_BITS-1:0] off0, mark0;
    eval_out_t              ev1, ev2;
    logic                   active, second, cons;
    logic [OFFSET_BITS+15:0] ext_begin, ext_finish;
    logic                   accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    assign st0   = s_tuser[0] ? S_MARKUP : state_reg;
    assign rt0   = s_tuser[0] ? S_IDLE : ret_reg;
    assign off0  = s_tuser[0] ? '0 : offset_reg;
    assign mark0 = s_tuser[0] ? '0 : mark_reg;

    xdr_eval u_eval0 (.state_i(st0), .ret_i(rt0), .char_i(s_tdata), .out_o(ev1));
    xdr_eval u_eval1 (.state_i(ev1.ns), .ret_i(ev1.nr), .char_i(s_tdata), .out_o(ev2));

    assign active = (st0 != S_IDLE);
    assign second = !ev1.cons && (ev1.ns != S_IDLE);
    assign cons   = active && (ev1.cons || (second && ev2.cons));

    always_comb begin
        state_next  = S_IDLE;
        ret_next    = rt0;
        v11_next    = v11_reg;
        mark_next   = mark0;
        offset_next = cons ? off0 + 1'b1 : off0;
        res_next    = '0;
        if (active) begin
            if (second) begin
                state_next = ev2.ns;
                ret_next   = ev2.nr;
            end else begin
                state_next = ev1.ns;
                ret_next   = ev1.nr;
            end
            if (ev1.mark_ld || (second && ev2.mark_ld)) begin
                mark_next = off0 + 1'b1;
            end
            if (ev1.v11_set || (second && ev2.v11_set)) begin
                v11_next = 1'b1;
            end
            res_next.token_kind = ev1.kind | (second ? ev2.kind : TK_NONE);
            res_next.error_code = (second && (ev2.err != ER_NONE)) ? ev2.err : ev1.err;
            res_next.handoff    = ev1.hand | (second ? ev2.hand : HO_STAY);
        end
        ext_begin  = {16'd0, mark0};
        ext_finish = {16'd0, off0};
        if (res_next.token_kind != TK_NONE) begin
            res_next.token_begin  = ext_begin[15:0];
            res_next.token_finish = ext_finish[15:0];
        end
        res_next.consumed       = cons;
        res_next.version_eleven = v11_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_MARKUP;
            ret_reg     <= S_IDLE;
            v11_reg     <= 1'b0;
            offset_reg  <= '0;
            mark_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg  <= state_next;
                ret_reg    <= ret_next;
                v11_reg    <= v11_next;
                offset_reg <= offset_next;
                mark_reg   <= mark_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    // every request yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("request accepted without result");

    // idle and not restarted: nothing consumed, no handoff
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_tuser[0] && (state_reg == S_IDLE))
        |=> (!res_reg.consumed && (res_reg.handoff == HO_STAY)))
        else $error("idle recognizer produced activity");

    // no token means zero span
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (res_reg.token_kind == TK_NONE))
        |-> ((res_reg.token_begin == 16'd0) && (res_reg.token_finish == 16'd0)))
        else $error("span reported without token");

    // version flag never clears once set
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(v11_reg) |-> v11_reg)
        else $error("version flag cleared");

endmodule
